// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the block's concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that holds on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lmic_pkg.sv =====
package lmic_pkg;

	localparam int AdcW   = 10;
	localparam int LevelW = 11;
	localparam int CountW = 16;
	localparam int DivW   = 8;
	localparam int BarW   = 8;
	localparam int PosW   = 3;
	localparam int CfgW   = 16;
	localparam int CfgIdxW = 2;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_TICK   = 1'b1
	} req_kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ADC_MIDPOINT    = 2'd0,
		CFG_QUIET_THRESHOLD = 2'd1,
		CFG_QUIET_LIMIT     = 2'd2,
		CFG_TICK_PERIOD     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		req_kind_t         kind;
		logic [AdcW-1:0]   sample;
	} req_t;

	localparam logic [AdcW-1:0]          MidpointRst  = 10'd512;
	localparam logic signed [LevelW-1:0] ThresholdRst = 11'sd32;
	localparam logic [CountW-1:0]        LimitRst     = 16'd100;
	localparam logic [DivW-1:0]          PeriodRst    = 8'd31;
	localparam logic [CountW-1:0]        CountMax     = 16'hFFFF;

	localparam logic signed [LevelW-1:0] BarThresholds [BarW] = '{
		11'sd32, 11'sd64, 11'sd80, 11'sd100, 11'sd120, 11'sd140, 11'sd160, 11'sd180
	};

	function automatic logic [BarW-1:0] thermometer(input logic signed [LevelW-1:0] level);
		logic [BarW-1:0] bits;
		bits = '0;
		for (int i = 0; i < BarW; i++) begin
			bits[i] = (level > BarThresholds[i]);
		end
		return bits;
	endfunction

endpackage

// ===== rtl/core/level_meter_with_idle_chaser.sv =====
// Order: a request enters the input register on acceptance; its result is shown
// when it moves on into the result register, which a held result can stall.
// Throughput: one request per cycle while out_ready takes each result; the meter,
// counter and chaser updates all happen in a single pass from the input register to the result register.
// Reset (arst_n low, asynchronous): registers take their default values, meter
// mode, counters cleared, all LEDs off, no request or result pending.
`include "assert_macros.svh"

module level_meter_with_idle_chaser import lmic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [AdcW-1:0]     adc_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BarW-1:0]     led_bar,
	output logic                chaser_mode
);

	logic [AdcW-1:0]          midpoint_q;
	logic signed [LevelW-1:0] threshold_q;
	logic [CountW-1:0]        limit_q;
	logic [DivW-1:0]          period_q;

	logic                     mode_q;
	logic [CountW-1:0]        count_q;
	logic [DivW-1:0]          div_q;
	logic [PosW-1:0]          pos_q;
	logic [BarW-1:0]          bar_q;

	req_t                     req_s1;
	logic                     valid_s1;
	logic                     out_valid_q;

	logic                     adv;
	logic signed [LevelW-1:0] level;
	logic                     quiet;
	logic [CountW-1:0]        count_d;
	logic                     mode_d;
	logic [DivW-1:0]          div_d;
	logic [PosW-1:0]          pos_d;
	logic [BarW-1:0]          bar_d;
	logic                     step;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midpoint_q  <= MidpointRst;
			threshold_q <= ThresholdRst;
			limit_q     <= LimitRst;
			period_q    <= PeriodRst;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ADC_MIDPOINT:    midpoint_q  <= cfg_data[AdcW-1:0];
				CFG_QUIET_THRESHOLD: threshold_q <= $signed(cfg_data[LevelW-1:0]);
				CFG_QUIET_LIMIT:     limit_q     <= cfg_data[CountW-1:0];
				CFG_TICK_PERIOD:     period_q    <= cfg_data[DivW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.kind   <= req_kind_t'(req_type);
			req_s1.sample <= adc_sample;
		end
	end

	assign level = $signed({1'b0, midpoint_q}) - $signed({1'b0, req_s1.sample});
	assign quiet = level < threshold_q;
	assign step  = mode_q && (div_q == period_q);

	always_comb begin
		count_d = count_q;
		mode_d  = mode_q;
		div_d   = div_q;
		pos_d   = pos_q;
		bar_d   = bar_q;
		case (req_s1.kind)
			REQ_SAMPLE: begin
				if (quiet) begin
					count_d = (count_q == CountMax) ? count_q : count_q + 1'b1;
					mode_d  = 1'b0;
				end else begin
					count_d = '0;
				end
				if (count_d > limit_q) begin
					mode_d = 1'b1;
				end
				if (!mode_d) begin
					bar_d = thermometer(level);
				end
			end
			REQ_TICK: begin
				if (mode_q) begin
					if (step) begin
						bar_d = BarW'(1) << pos_q;
						pos_d = pos_q + 1'b1;
						div_d = DivW'(1);
					end else begin
						div_d = div_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			count_q     <= '0;
			div_q       <= '0;
			pos_q       <= '0;
			bar_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				mode_q      <= mode_d;
				count_q     <= count_d;
				div_q       <= div_d;
				pos_q       <= pos_d;
				bar_q       <= bar_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign led_bar     = bar_q;
	assign chaser_mode = mode_q;

	`ASSERT_CLK(a_adv_shows_result, adv |=> out_valid_q, "request advanced but no result shown")
	`ASSERT_CLK(a_pos_held_in_meter, (adv && !mode_q) |=> $stable(pos_q),
		"chase position moved in meter mode")
	`ASSERT_CLK(a_chase_onehot, (adv && req_s1.kind == REQ_TICK && step) |=> $onehot(bar_q),
		"chaser step did not light exactly one LED")
	`ASSERT_ALWAYS(a_stall_holds, (out_valid_q && !out_ready && arst_n) |=>
		(!arst_n || out_valid_q), "result dropped while stalled")

endmodule

// ===== bench/level_meter_with_idle_chaser_tb.sv =====
module level_meter_with_idle_chaser_tb import lmic_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MeterSteps [BarW] = '{32, 64, 80, 100, 120, 140, 160, 180};
	localparam int QuietFull = 65535;

	class bar_scoreboard;
		typedef struct {
			logic [BarW-1:0] bar;
			logic            chaser;
		} bar_view_t;

		int              midpoint;
		int              threshold;
		int              limit;
		logic [DivW-1:0] period;

		logic            chaser;
		int              quiet_run;
		logic [DivW-1:0] divider;
		logic [PosW-1:0] position;
		logic [BarW-1:0] pattern;

		bar_view_t shown_q [$];
		int mismatches;
		int requests_seen;
		int results_seen;
		int chaser_entries;
		int chaser_steps;
		int full_hits;

		function new();
			midpoint       = MidpointRst;
			threshold      = ThresholdRst;
			limit          = LimitRst;
			period         = PeriodRst;
			chaser         = 1'b0;
			quiet_run      = 0;
			divider        = '0;
			position       = '0;
			pattern        = '0;
			mismatches     = 0;
			requests_seen  = 0;
			results_seen   = 0;
			chaser_entries = 0;
			chaser_steps   = 0;
			full_hits      = 0;
		endfunction

		function void write_register(cfg_idx_t idx, logic [CfgW-1:0] value);
			case (idx)
				CFG_ADC_MIDPOINT:    midpoint = value[AdcW-1:0];
				CFG_QUIET_THRESHOLD: threshold = $signed(value[LevelW-1:0]);
				CFG_QUIET_LIMIT:     limit = value;
				CFG_TICK_PERIOD:     period = value[DivW-1:0];
				default: ;
			endcase
		endfunction

		function logic [BarW-1:0] bar_for_level(int level);
			logic [BarW-1:0] bits;
			for (int i = 0; i < BarW; i++) begin
				bits[i] = (level > MeterSteps[i]);
			end
			return bits;
		endfunction

		function void note_request(logic kind, logic [AdcW-1:0] sample);
			int        level;
			logic      was_chaser;
			bar_view_t view;
			requests_seen++;
			was_chaser = chaser;
			if (kind == REQ_SAMPLE) begin
				level = midpoint - int'(sample);
				if (level < threshold) begin
					if (quiet_run < QuietFull) quiet_run++;
					else full_hits++;
					chaser = 1'b0;
				end else begin
					quiet_run = 0;
				end
				if (quiet_run > limit) chaser = 1'b1;
				if (chaser && !was_chaser) chaser_entries++;
				if (!chaser) pattern = bar_for_level(level);
			end else if (chaser) begin
				if (divider == period) begin
					pattern  = BarW'(1) << position;
					position = position + 1'b1;
					divider  = '0;
					chaser_steps++;
				end
				divider = divider + 1'b1;
			end
			view.bar    = pattern;
			view.chaser = chaser;
			shown_q.push_back(view);
		endfunction

		function void check_result(logic [BarW-1:0] bar, logic mode);
			bar_view_t want;
			results_seen++;
			if (shown_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request: led_bar %h chaser_mode %b",
						$realtime, bar, mode);
				return;
			end
			want = shown_q.pop_front();
			if (bar !== want.bar || mode !== want.chaser) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: led_bar %h chaser_mode %b, expected led_bar %h chaser_mode %b",
						$realtime, bar, mode, want.bar, want.chaser);
			end
		endfunction

		function int pending();
			return shown_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_SAMPLE;
	logic [AdcW-1:0]    adc_sample = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BarW-1:0]    led_bar;
	logic               chaser_mode;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	bar_scoreboard sb;

	level_meter_with_idle_chaser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.adc_sample  (adc_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.led_bar     (led_bar),
		.chaser_mode (chaser_mode)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_request(req_type, adc_sample);
			if (out_valid && out_ready) sb.check_result(led_bar, chaser_mode);
		end
	end

	task automatic send_request(req_kind_t kind, logic [AdcW-1:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		adc_sample <= sample;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, AdcW'($urandom));
	endtask

	function automatic logic [AdcW-1:0] quiet_sample();
		int lo;
		lo = sb.midpoint - sb.threshold + 1;
		if (lo < 0) lo = 0;
		if (lo > 1023) return AdcW'($urandom);
		return AdcW'($urandom_range(1023, lo));
	endfunction

	function automatic logic [AdcW-1:0] loud_sample();
		int hi;
		hi = sb.midpoint - sb.threshold;
		if (hi < 0) return AdcW'($urandom);
		if (hi > 1023) hi = 1023;
		return AdcW'($urandom_range(hi, 0));
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_register(cfg_idx_t idx, logic [CfgW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_register(idx, value);
	endtask

	task automatic apply_settings(int mid, int thr, int lim, int per);
		put_register(CFG_ADC_MIDPOINT, CfgW'(mid[AdcW-1:0]));
		put_register(CFG_QUIET_THRESHOLD, CfgW'(thr[LevelW-1:0]));
		put_register(CFG_QUIET_LIMIT, CfgW'(lim[CountW-1:0]));
		put_register(CFG_TICK_PERIOD, CfgW'(per[DivW-1:0]));
		cfg_we <= 1'b0;
	endtask

	task automatic pick_settings();
		int mid;
		int thr;
		int lim;
		int per;
		if ($urandom_range(3) == 0) mid = $urandom_range(1) ? 1023 : 0;
		else mid = $urandom_range(1023);
		if ($urandom_range(3) == 0) thr = $urandom_range(1) ? 1023 : -1024;
		else thr = int'($urandom_range(300)) - 100;
		case ($urandom_range(7))
			0: lim = 0;
			1: lim = 65534;
			2: lim = 65535;
			default: lim = $urandom_range(24);
		endcase
		case ($urandom_range(7))
			0: per = 0;
			1: per = 255;
			2: per = 1;
			default: per = $urandom_range(12);
		endcase
		apply_settings(mid, thr, lim, per);
	endtask

	task automatic run_random(int count);
		int sent;
		int run;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				run = (sb.limit < 40) ? sb.limit + 1 + $urandom_range(2) : $urandom_range(8, 1);
				repeat (run) send_request(REQ_SAMPLE, quiet_sample());
				sent += run;
				run = $urandom_range(($urandom_range(7) == 0) ? 2 * int'(sb.period) + 2 : 12, 1);
				if (run > count - sent) run = count - sent;
				repeat (run) send_tick();
				sent += run;
			end else if (pick < 70) begin
				run = $urandom_range(8, 1);
				repeat (run) send_request(REQ_SAMPLE, loud_sample());
				sent += run;
			end else if (pick < 85) begin
				run = $urandom_range(10, 1);
				repeat (run) send_tick();
				sent += run;
			end else begin
				send_request(req_kind_t'($urandom_range(1)), AdcW'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 51;
		send_request(REQ_SAMPLE, 10'd0);
		send_request(REQ_SAMPLE, 10'd1023);
		send_request(REQ_SAMPLE, 10'd480);
		send_request(REQ_SAMPLE, 10'd479);
		send_request(REQ_SAMPLE, 10'd448);
		send_request(REQ_SAMPLE, 10'd447);
		send_request(REQ_SAMPLE, 10'd431);
		send_request(REQ_SAMPLE, 10'd332);
		send_request(REQ_SAMPLE, 10'd331);
		send_request(REQ_TICK, 10'h3FF);
		send_request(REQ_TICK, 10'h000);
		send_request(REQ_SAMPLE, 10'h155);
		send_request(REQ_SAMPLE, 10'h2AA);
		drain();

		// everything but a zero sample is quiet; a single quiet sample enters chaser
		apply_settings(1023, 1023, 0, 0);
		send_request(REQ_SAMPLE, 10'd1023);
		send_tick();
		send_tick();
		send_tick();
		send_request(REQ_SAMPLE, 10'd0);
		send_tick();
		send_request(REQ_SAMPLE, 10'd512);
		send_tick();
		drain();

		apply_settings(0, -1024, 65534, 255);
		run_random(60);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 51 : 0;
			recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 34 : 0;
			repeat (2) begin
				pick_settings();
				run_random(125);
				drain();
			end
		end

		// keep the meter on: a limit of 65535 is never exceeded
		apply_settings(1023, 1023, 65535, 3);
		repeat (30) send_request(REQ_SAMPLE, AdcW'($urandom_range(1023, 1)));
		repeat (10) send_tick();
		drain();

		$display("Run covered %0d requests and %0d checked results, %0d mismatching.",
			sb.requests_seen, sb.results_seen, sb.mismatches);
		$display("Chaser mode entered %0d times with %0d steps; quiet counter held full %0d times.",
			sb.chaser_entries, sb.chaser_steps, sb.full_hits);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#24_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
